### src/lutf8_pkg.sv
// Shared types, constants and byte classifier for the lenient UTF-8 decoder.
// No dependencies; compiled first.
package lutf8_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CONT_BITS   = 6;
    localparam int QUEUE_DEPTH = 4;

    // Lead / continuation byte patterns
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD4_DATA = 8'h07;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD3_DATA = 8'h0F;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD2_DATA = 8'h1F;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] CONT_DATA  = 8'h3F;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_OTHER
    } t_byte_class;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
    } t_byte_item;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            cut_short;
        logic            last;
    } t_result_item;

    // Results produced by one decoded byte, packed to the front.
    typedef struct packed {
        logic [1:0]   count;
        t_result_item res0;
        t_result_item res1;
    } t_dec_push;

    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class cls;
        if (b == '0) begin
            cls = CLS_END;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            cls = CLS_LEAD4;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            cls = CLS_LEAD3;
        end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            cls = CLS_LEAD2;
        end else if ((b & CONT_MASK) == CONT_PAT) begin
            cls = CLS_CONT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

### src/lutf8_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies; payload type is set at instantiation.
interface lutf8_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/lutf8_decode.sv
// Decode step: sequence state plus the combinational byte handling.
// Depends on lutf8_pkg.
module lutf8_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [lutf8_pkg::BYTE_W-1:0]      i_byte,
    output lutf8_pkg::t_dec_push              o_push
);
    import lutf8_pkg::*;

    logic [1:0]      r_pending, n_pending;
    logic [CP_W-1:0] r_partial, n_partial;

    t_byte_class     cls;
    logic [CP_W-1:0] shifted;
    logic            fresh;
    logic            cut_valid, done_valid, emit_valid;
    logic [1:0]      count;
    t_result_item    res_cut, res_done, res_emit;

    always_comb begin
        cls        = classify(i_byte);
        shifted    = {r_partial[CP_W-CONT_BITS-1:0], i_byte[CONT_BITS-1:0]};
        n_pending  = r_pending;
        n_partial  = r_partial;
        fresh      = 1'b1;
        cut_valid  = 1'b0;
        done_valid = 1'b0;
        emit_valid = 1'b0;

        if (r_pending != 2'd0) begin
            if (cls == CLS_CONT) begin
                fresh     = 1'b0;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    done_valid = 1'b1;
                    n_partial  = '0;
                end else begin
                    n_partial = shifted;
                end
            end else begin
                // open sequence interrupted: flush it, then treat byte as new
                cut_valid = 1'b1;
                n_pending = 2'd0;
                n_partial = '0;
            end
        end

        if (fresh) begin
            case (cls)
                CLS_END: begin
                end
                CLS_LEAD4: begin
                    n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & LEAD4_DATA};
                    n_pending = 2'd3;
                end
                CLS_LEAD3: begin
                    n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & LEAD3_DATA};
                    n_pending = 2'd2;
                end
                CLS_LEAD2: begin
                    n_partial = {{(CP_W-BYTE_W){1'b0}}, i_byte & LEAD2_DATA};
                    n_pending = 2'd1;
                end
                default: begin
                    emit_valid = 1'b1;
                end
            endcase
        end

        count = 2'({1'b0, cut_valid}) + 2'({1'b0, done_valid}) + 2'({1'b0, emit_valid});

        res_cut  = '{codepoint: r_partial, cut_short: 1'b1, last: 1'b0};
        res_done = '{codepoint: shifted, cut_short: 1'b0, last: 1'b0};
        res_emit = '{codepoint: {{(CP_W-BYTE_W){1'b0}}, i_byte}, cut_short: 1'b0,
                     last: 1'b0};

        o_push.count = i_fire ? count : 2'd0;
        o_push.res0  = cut_valid ? res_cut : (done_valid ? res_done : res_emit);
        o_push.res0.last = (count == 2'd1);
        o_push.res1  = res_emit;
        o_push.res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

endmodule

### src/lutf8_out_queue.sv
// Small result queue: takes up to two results per cycle, hands out one while ready.
// Depends on lutf8_pkg.
module lutf8_out_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lutf8_pkg::t_dec_push     i_push,
    output logic                     o_room,
    output logic                     o_valid,
    output lutf8_pkg::t_result_item  o_item,
    input  logic                     i_ready
);
    import lutf8_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result_item     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop;
    logic [CNT_W-1:0] occ;

    always_comb begin
        pop     = (r_count != '0) && i_ready;
        occ     = r_count - CNT_W'(pop);
        o_room  = (occ <= CNT_W'(QUEUE_DEPTH - 2));
        o_valid = (r_count != '0);
        o_item  = r_mem[r_rd];
        wr_next = r_wr + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

endmodule

### src/lenient_utf8_stream_decoder_core.sv
// Top level of the lenient UTF-8 stream decoder.
// Depends on lutf8_pkg, lutf8_stream_if, lutf8_decode, lutf8_out_queue.

// Lenient UTF-8 decoder: one byte per input transaction, one code point per
// output transaction. Lead bytes open 2-, 3- or 4-byte sequences, continuation
// bytes shift in six bits each, and a complete sequence yields its code point.
// Any other byte is passed through as its own value. A non-continuation byte
// that arrives inside a sequence first flushes the partial value with
// cut_short set, then is handled on its own, so it can yield two results;
// 'last' marks the final result of each byte. Byte zero flushes an open
// sequence and yields nothing itself. No overlong, surrogate or range checks.
// Rate: one byte per cycle while the result queue has room. A byte that yields
// two results needs two output transactions; a 4-entry result queue absorbs
// these, and input stalls only when fewer than two queue slots will be free. A
// result is offered once its byte has passed the input register and been decoded
// into the queue; the output valid and payload come straight from registers.
module lenient_utf8_stream_decoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lutf8_stream_if.sink    i_byte,
    lutf8_stream_if.source  o_result
);
    import lutf8_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic              room;
    logic              consume;
    t_dec_push         push;
    t_result_item      q_item;
    t_byte_item        in_item;

    assign in_item      = i_byte.payload;
    // byte in the input register is decoded when the queue can take two results
    assign consume      = r_in_valid && room;
    assign i_byte.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= in_item.byte_in;
        end
    end

    lutf8_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (consume),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    lutf8_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_result.valid),
        .o_item  (q_item),
        .i_ready (o_result.ready)
    );

    assign o_result.payload = q_item;

endmodule

### tb/sv/lenient_utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lenient_utf8_stream_decoder_core.
// Depends on lutf8_pkg and lutf8_stream_if; a local decoder model predicts every code point.

module lenient_utf8_stream_decoder_core_tb;

    import lutf8_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 6;
    localparam int DRAIN_CYCLES = 8;      // extra wait after the last expected result
    localparam int WD_LIMIT     = 4000;   // idle cycles before the run is declared hung
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lutf8_stream_if #(.t_payload(t_byte_item))   byte_ch ();
    lutf8_stream_if #(.t_payload(t_result_item)) result_ch ();

    lenient_utf8_stream_decoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Decoder state mirrored by the model
    logic [1:0]      cont_left = '0;
    logic [CP_W-1:0] gathered  = '0;

    t_result_item expected_codepoints[$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    // Appends the results one byte causes; 'last' goes on the final one.
    function automatic void predict_codepoints(input logic [BYTE_W-1:0] b);
        t_result_item r;
        int           n0;
        bit           consumed;
        n0       = expected_codepoints.size();
        consumed = 1'b0;
        if (cont_left != 2'd0) begin
            if ((b & CONT_MASK) == CONT_PAT) begin
                gathered  = {gathered[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    r.codepoint = gathered;
                    r.cut_short = 1'b0;
                    r.last      = 1'b0;
                    expected_codepoints.push_back(r);
                    gathered = '0;
                end
                consumed = 1'b1;
            end else begin
                // sequence interrupted: flush what was gathered, flagged
                r.codepoint = gathered;
                r.cut_short = 1'b1;
                r.last      = 1'b0;
                expected_codepoints.push_back(r);
                cont_left = '0;
                gathered  = '0;
            end
        end
        if (!consumed) begin
            if (b == '0) begin
                // end of string emits nothing itself
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                gathered  = CP_W'(b & LEAD4_DATA);
                cont_left = 2'd3;
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                gathered  = CP_W'(b & LEAD3_DATA);
                cont_left = 2'd2;
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                gathered  = CP_W'(b & LEAD2_DATA);
                cont_left = 2'd1;
            end else begin
                r.codepoint = CP_W'(b);
                r.cut_short = 1'b0;
                r.last      = 1'b0;
                expected_codepoints.push_back(r);
            end
        end
        if (expected_codepoints.size() > n0)
            expected_codepoints[expected_codepoints.size()-1].last = 1'b1;
    endfunction

    // One input transaction; valid stays high if the next byte follows at once.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_byte_item item;
        item.byte_in = b;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= item;
        do @(posedge i_clk); while (!(byte_ch.valid && byte_ch.ready));
        predict_codepoints(b);
        bytes_sent++;
    endtask

    // Lead byte of a len-byte sequence followed by n_cont continuations.
    task automatic send_sequence(input int len, input int n_cont);
        logic [BYTE_W-1:0] lead;
        case (len)
            2:       lead = LEAD2_PAT | (8'($urandom) & LEAD2_DATA);
            3:       lead = LEAD3_PAT | (8'($urandom) & LEAD3_DATA);
            default: lead = LEAD4_PAT | (8'($urandom) & LEAD4_DATA);
        endcase
        send_byte(lead);
        repeat (n_cont) send_byte(CONT_PAT | (8'($urandom) & CONT_DATA));
    endtask

    task automatic drain;
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (expected_codepoints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed;
        logic [BYTE_W-1:0] seq[] = '{
            8'h7F,                          // plain ASCII top
            8'h80,                          // stray continuation
            8'hFF,                          // stray 11111xxx
            8'hE2, 8'h82, 8'hAC,            // 3-byte
            8'hF0, 8'h9F, 8'h98, 8'h80,     // 4-byte
            8'hF7, 8'hBF, 8'hBF, 8'hBF,     // largest 21-bit value
            8'hC0, 8'h80,                   // smallest 2-byte
            8'hE2, 8'h82, 8'h41,            // cut by ASCII: two results
            8'hF0, 8'h00,                   // cut by end of string
            8'h00,                          // end of string, nothing open
            8'hC3, 8'hE2, 8'h82, 8'hAC      // cut by a new lead
        };
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (seq[i]) send_byte(seq[i]);
        drain();
    endtask

    // Mostly well-formed text with random payloads, plus truncations and noise.
    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int rx_pct);
        int start;
        int pick;
        int len;
        send_idle_pct = idle_pct;
        stall_pct     = rx_pct;
        start         = bytes_sent;
        while (bytes_sent - start < n_items) begin
            pick = $urandom_range(99);
            len  = $urandom_range(2, 4);
            if (pick < 28) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (pick < 70) begin
                send_sequence(len, len - 1);
            end else if (pick < 80) begin
                send_sequence(len, $urandom_range(0, len - 2));
            end else if (pick < 86) begin
                send_byte(CONT_PAT | (8'($urandom) & CONT_DATA));
            end else if (pick < 90) begin
                send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end else if (pick < 95) begin
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        drain();
    endtask

    // Receiver holds off; ASCII after a lead gives two results: queue fills, input stalls.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        stall_pct      = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) begin
            send_sequence($urandom_range(2, 4), 0);
            send_byte(8'($urandom_range(1, 127)));
        end
        drain();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            result_ch.ready <= 1'b0;
            rx_hold_cycles  <= rx_hold_cycles - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_result_item want;
        t_result_item got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.payload;
            if (expected_codepoints.size() == 0) begin
                $error("unexpected result: codepoint=%06h cut_short=%0b last=%0b",
                       got.codepoint, got.cut_short, got.last);
                mismatch_count++;
            end else begin
                want = expected_codepoints.pop_front();
                if (got.codepoint !== want.codepoint) begin
                    $error("codepoint: expected %06h, actual %06h",
                           want.codepoint, got.codepoint);
                    mismatch_count++;
                end
                if (got.cut_short !== want.cut_short) begin
                    $error("cut_short: expected %0b, actual %0b",
                           want.cut_short, got.cut_short);
                    mismatch_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: consecutive cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.payload = '0;
        result_ch.ready = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream(250, 0, 0);
        test_random_stream(250, 88, 0);
        test_random_stream(250, 0, 88);
        test_random_stream(250, 20, 20);
        test_backpressure();

        if (mismatch_count == 0 && expected_codepoints.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
